@@ rtl/pnpf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnpf_pkg
// Shared constants and types for the periodic neighbor pair finder.
// ----------------------------------------------------------------------------
package pnpf_pkg;
  localparam int MAX_ATOMS_DEF  = 64;
  localparam int COORD_BITS_DEF = 20;
  localparam int IDX_BITS       = 6;
  localparam int CNT_BITS       = 7;
  localparam int CFG_BITS       = 20;
  localparam int CFG_IDX_BITS   = 3;

  localparam logic [CFG_IDX_BITS-1:0] REG_BOX_X  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_BOX_Y  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_BOX_Z  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_CUTOFF = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_COUNT  = 3'd4;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] SHIFT_POS  = 2'b01;
  localparam logic [1:0] SHIFT_NEG  = 2'b11;
  localparam logic [1:0] SHIFT_NONE = 2'b00;

  // Per-candidate tag that travels down the cell chain.
  typedef struct packed {
    logic                valid;
    logic                fin;
    logic [IDX_BITS-1:0] idx;
  } tag_t;
endpackage

@@ rtl/pnpf_axis_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnpf_axis_cell
// One chain cell: wraps one axis difference, squares it and adds it to the
// running sum passed from the previous cell.
// ----------------------------------------------------------------------------
module pnpf_axis_cell #(
  parameter int COORD_BITS = pnpf_pkg::COORD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  pnpf_pkg::tag_t          tag_in,
  input  logic [COORD_BITS-1:0]   pi,
  input  logic [COORD_BITS-1:0]   pj,
  input  logic [COORD_BITS-1:0]   len,
  input  logic [COORD_BITS-1:0]   cutoff,
  input  logic                    ok_in,
  input  logic [2*COORD_BITS+1:0] acc_in,
  input  logic [5:0]              sh_in,
  output pnpf_pkg::tag_t          tag_out,
  output logic                    ok_out,
  output logic [2*COORD_BITS+1:0] acc_out,
  output logic [5:0]              sh_out
);
  import pnpf_pkg::*;

  localparam int DW = COORD_BITS + 2;
  localparam int AW = 2 * COORD_BITS + 2;

  logic signed [DW-1:0] d, l, w;
  logic [COORD_BITS:0]  m;
  logic [1:0]           sh;
  logic [AW-1:0]        sq;

  always_comb begin
    d = $signed({2'b00, pi}) - $signed({2'b00, pj});
    l = $signed({2'b00, len});
    if ((d <<< 1) > l) begin
      sh = SHIFT_POS;
      w  = d - l;
    end else if ((d <<< 1) < -l) begin
      sh = SHIFT_NEG;
      w  = d + l;
    end else begin
      sh = SHIFT_NONE;
      w  = d;
    end
    m  = w[DW-1] ? (~w[COORD_BITS:0] + 1'b1) : w[COORD_BITS:0];
    sq = AW'(m) * AW'(m);
  end

  // Abs of the wrapped difference stays under the cutoff, so it is below 2^20
  // whenever the pair is still live; the sum compare is done at the end.
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out <= '0;
    end else begin
      tag_out <= tag_in;
    end
    ok_out  <= ok_in && (m < {1'b0, cutoff});
    acc_out <= acc_in + sq;
    sh_out  <= {sh_in[3:0], sh};
  end
endmodule

@@ rtl/periodic_neighbor_pair_finder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_neighbor_pair_finder
// Cutoff neighbor search with minimum-image wrap in an orthorhombic box.
// ----------------------------------------------------------------------------
// A write transaction (opcode 0) stores x, y, z for one atom and returns no
// result. A query transaction (opcode 1) reads the center atom, then streams
// atoms 0 .. min(atom_count, MAX_ATOMS)-1 from the position memory one per
// cycle into a chain of three axis cells (x, y, z) and a final compare
// stage. The memory read port sets the pace: after a query is taken, busy
// stays high until the cycle in which its last result is shown. Results
// appear on the output ports with strobe high for exactly one cycle each;
// the receiver cannot stall them, so take every strobe. A query with no
// pair gives one result with found low. Atom indices beyond the memory wrap
// modulo MAX_ATOMS.
// ----------------------------------------------------------------------------
module periodic_neighbor_pair_finder #(
  parameter int COORD_BITS = pnpf_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [pnpf_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [pnpf_pkg::CFG_BITS-1:0] cfg_data,
  input  logic                          start,
  output logic                          busy,
  input  logic                          opcode,
  input  logic [pnpf_pkg::IDX_BITS-1:0] atom_index,
  input  logic [COORD_BITS-1:0]         pos_x,
  input  logic [COORD_BITS-1:0]         pos_y,
  input  logic [COORD_BITS-1:0]         pos_z,
  output logic                          strobe,
  output logic [pnpf_pkg::IDX_BITS-1:0] center_index,
  output logic [pnpf_pkg::IDX_BITS-1:0] neighbor_index,
  output logic signed [1:0]             shift_x,
  output logic signed [1:0]             shift_y,
  output logic signed [1:0]             shift_z,
  output logic                          found,
  output logic                          last
);
  import pnpf_pkg::*;

  localparam int MAX_ATOMS = MAX_ATOMS_DEF;
  localparam int AB = $clog2(MAX_ATOMS);
  localparam int JB = AB + 1;
  localparam int AW = 2 * COORD_BITS + 2;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CTR  = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_END  = 2'd3;

  logic [COORD_BITS-1:0] box_x, box_y, box_z, cutoff;
  logic [CNT_BITS-1:0]   atom_count;
  logic [3*COORD_BITS-1:0] mem [MAX_ATOMS];
  logic [3*COORD_BITS-1:0] rd, ctr;

  logic [1:0]    state;
  logic [JB-1:0] j, n;
  logic [AB-1:0] ci;
  logic [JB-1:0] hits;
  logic [AW-1:0] c2;
  tag_t          rtag, t0, t1, t2;
  logic          ok0, ok1, ok2;
  logic [AW-1:0] a0, a1, a2;
  logic [5:0]    s0, s1, s2;
  logic          hit;
  logic          full;
  logic          pend_v;
  logic [AB-1:0] pend_idx;
  logic [5:0]    pend_sh;
  logic [COORD_BITS-1:0] ryd, rzd1, rzd2;

  // Hold configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      box_x <= '1; box_y <= '1; box_z <= '1; cutoff <= '0; atom_count <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BOX_X:  box_x  <= COORD_BITS'(cfg_data);
        REG_BOX_Y:  box_y  <= COORD_BITS'(cfg_data);
        REG_BOX_Z:  box_z  <= COORD_BITS'(cfg_data);
        REG_CUTOFF: cutoff <= COORD_BITS'(cfg_data);
        REG_COUNT:  atom_count <= cfg_data[CNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) c2 <= AW'(cutoff) * AW'(cutoff);

  assign busy = (state != ST_IDLE);
  wire accept = start && !busy;

  // Position memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (accept && opcode == OP_WRITE)
      mem[AB'(atom_index)] <= {pos_x, pos_y, pos_z};
    rd <= mem[(state == ST_IDLE) ? AB'(atom_index) : j[AB-1:0]];
  end

  // Scan sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rtag  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          rtag <= '0;
          if (accept && opcode == OP_QUERY) begin
            state <= ST_CTR;
            ci    <= AB'(atom_index);
            j     <= '0;
            n     <= (atom_count > CNT_BITS'(MAX_ATOMS)) ? JB'(MAX_ATOMS)
                                                         : JB'(atom_count);
          end
        end
        ST_CTR: begin
          rtag  <= '0;
          ctr   <= rd;
          state <= ST_SCAN;
        end
        ST_SCAN: begin
          // Advance one atom per cycle; the tag and the read data move together.
          if (j < n) begin
            rtag <= '{valid: (j[AB-1:0] != ci), fin: 1'b0,
                      idx: IDX_BITS'(j[AB-1:0])};
            j    <= j + 1'b1;
          end else begin
            rtag  <= '{valid: 1'b0, fin: 1'b1, idx: '0};
            state <= ST_END;
          end
        end
        ST_END: begin
          rtag <= '0;
          if (strobe && last) state <= ST_IDLE;
        end
        default: begin
          rtag  <= '0;
          state <= ST_IDLE;
        end
      endcase
    end
  end

  pnpf_axis_cell #(.COORD_BITS(COORD_BITS)) u_x (
    .clk, .rst, .tag_in(rtag), .pi(ctr[3*COORD_BITS-1 -: COORD_BITS]),
    .pj(rd[3*COORD_BITS-1 -: COORD_BITS]), .len(box_x), .cutoff(cutoff),
    .ok_in(1'b1), .acc_in('0), .sh_in(6'd0),
    .tag_out(t0), .ok_out(ok0), .acc_out(a0), .sh_out(s0));
  pnpf_axis_cell #(.COORD_BITS(COORD_BITS)) u_y (
    .clk, .rst, .tag_in(t0), .pi(ctr[2*COORD_BITS-1 -: COORD_BITS]),
    .pj(ryd), .len(box_y), .cutoff(cutoff),
    .ok_in(ok0), .acc_in(a0), .sh_in(s0),
    .tag_out(t1), .ok_out(ok1), .acc_out(a1), .sh_out(s1));
  pnpf_axis_cell #(.COORD_BITS(COORD_BITS)) u_z (
    .clk, .rst, .tag_in(t1), .pi(ctr[COORD_BITS-1:0]),
    .pj(rzd2), .len(box_z), .cutoff(cutoff),
    .ok_in(ok1), .acc_in(a1), .sh_in(s1),
    .tag_out(t2), .ok_out(ok2), .acc_out(a2), .sh_out(s2));

  // Delay y and z of the neighbor to line up with their cells.
  always_ff @(posedge clk) begin
    ryd  <= rd[2*COORD_BITS-1 -: COORD_BITS];
    rzd1 <= rd[COORD_BITS-1:0];
    rzd2 <= rzd1;
  end

  assign hit  = t2.valid && ok2 && (a2 < c2);
  assign full = (hits == JB'(MAX_ATOMS - 1));

  // Hold one pending pair so that last can be set on the final one.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v <= 1'b0; strobe <= 1'b0; hits <= '0;
    end else begin
      if (accept) begin
        strobe <= 1'b0; hits <= '0; pend_v <= 1'b0;
      end else if (hit && !full) begin
        strobe <= pend_v;
        if (pend_v) begin
          found <= 1'b1; last <= 1'b0;
          neighbor_index <= IDX_BITS'(pend_idx);
          {shift_x, shift_y, shift_z} <= pend_sh;
        end
        pend_v   <= 1'b1;
        pend_idx <= t2.idx[AB-1:0];
        pend_sh  <= s2;
        hits     <= hits + 1'b1;
      end else if (t2.fin) begin
        strobe <= 1'b1; last <= 1'b1;
        pend_v <= 1'b0;
        found  <= pend_v;
        neighbor_index <= pend_v ? IDX_BITS'(pend_idx) : '0;
        {shift_x, shift_y, shift_z} <= pend_v ? pend_sh : 6'd0;
      end else begin
        strobe <= 1'b0;
      end
      center_index <= IDX_BITS'(ci);
    end
  end
endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the periodic neighbor pair finder. Loads atom
// positions, issues neighbor queries under several box and cutoff settings,
// predicts every pair with minimum-image wrap, and checks each strobed result.
// ----------------------------------------------------------------------------
module tb;
  import pnpf_pkg::*;

  localparam int NATOM = MAX_ATOMS_DEF;
  localparam int CB    = COORD_BITS_DEF;

  typedef struct {
    logic                op;
    logic [IDX_BITS-1:0] idx;
    logic [CB-1:0]       x, y, z;
  } cmd_t;

  typedef struct {
    logic [IDX_BITS-1:0] center, neighbor;
    logic [1:0]          sx, sy, sz;
    logic                found, last;
  } pair_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_BITS-1:0] cfg_data = '0;
  logic start = 1'b0;
  logic busy;
  logic opcode = OP_WRITE;
  logic [IDX_BITS-1:0] atom_index = '0;
  logic [CB-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic strobe;
  logic [IDX_BITS-1:0] center_index, neighbor_index;
  logic signed [1:0] shift_x, shift_y, shift_z;
  logic found, last;

  periodic_neighbor_pair_finder dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .start(start), .busy(busy), .opcode(opcode),
    .atom_index(atom_index), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .strobe(strobe), .center_index(center_index),
    .neighbor_index(neighbor_index), .shift_x(shift_x), .shift_y(shift_y),
    .shift_z(shift_z), .found(found), .last(last)
  );

  // Shadow of the block's registers and position memory
  logic [CB-1:0] box_len [3];
  logic [CB-1:0] cut_r;
  logic [CNT_BITS-1:0] scan_cnt;
  logic [CB-1:0] atom_pos [NATOM][3];

  cmd_t  cmd_q[$];      // transactions waiting for the driver
  pair_t pair_q[$];     // pairs still owed by the block
  cmd_t  cur;
  bit    staged [NATOM]; // atoms written by the generated stream so far
  int    sender_idle = 11;
  int    errs = 0;

  initial forever #5 clk = ~clk;

  // Build the pair list for one query from the shadow state.
  task automatic predict_pairs(input logic [IDX_BITS-1:0] ci);
    int n, cnt;
    longint d, l, w, acc;
    logic [1:0] sh [3];
    pair_t p;
    n = (scan_cnt > NATOM) ? NATOM : scan_cnt;
    cnt = 0;
    for (int j = 0; j < n && cnt < NATOM - 1; j++) begin
      if (j == ci) continue;
      acc = 0;
      for (int a = 0; a < 3; a++) begin
        d = longint'(atom_pos[ci][a]) - longint'(atom_pos[j][a]);
        l = longint'(box_len[a]);
        if (2 * d > l) begin
          sh[a] = SHIFT_POS; w = d - l;
        end else if (2 * d < -l) begin
          sh[a] = SHIFT_NEG; w = d + l;
        end else begin
          sh[a] = SHIFT_NONE; w = d;
        end
        acc += w * w;
      end
      if (acc < longint'(cut_r) * longint'(cut_r)) begin
        p.center = ci; p.neighbor = IDX_BITS'(j);
        p.sx = sh[0]; p.sy = sh[1]; p.sz = sh[2];
        p.found = 1'b1; p.last = 1'b0;
        pair_q = {pair_q, p};
        cnt++;
      end
    end
    if (cnt == 0) begin
      p.center = ci; p.neighbor = '0;
      p.sx = SHIFT_NONE; p.sy = SHIFT_NONE; p.sz = SHIFT_NONE;
      p.found = 1'b0; p.last = 1'b1;
      pair_q = {pair_q, p};
    end else begin
      pair_q[pair_q.size() - 1].last = 1'b1;
    end
  endtask

  // Driver: hold a transaction while busy, account for it once taken.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) begin
        if (cur.op == OP_WRITE) begin
          atom_pos[cur.idx][0] = cur.x;
          atom_pos[cur.idx][1] = cur.y;
          atom_pos[cur.idx][2] = cur.z;
        end else begin
          predict_pairs(cur.idx);
        end
      end
      if (cmd_q.size() > 0 && $urandom_range(99) >= sender_idle) begin
        cur = cmd_q.pop_front();
        opcode <= cur.op;
        atom_index <= cur.idx;
        pos_x <= cur.x;
        pos_y <= cur.y;
        pos_z <= cur.z;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobe must match the oldest owed pair.
  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (pair_q.size() == 0) begin
        $error("unexpected result center=%0d neighbor=%0d", center_index,
               neighbor_index);
        errs++;
      end else begin
        pair_t e;
        e = pair_q.pop_front();
        if (center_index !== e.center) begin
          $error("center_index exp %0d got %0d", e.center, center_index); errs++;
        end
        if (neighbor_index !== e.neighbor) begin
          $error("neighbor_index exp %0d got %0d", e.neighbor, neighbor_index);
          errs++;
        end
        if (shift_x !== e.sx) begin
          $error("shift_x exp %0d got %0d", $signed(e.sx), shift_x); errs++;
        end
        if (shift_y !== e.sy) begin
          $error("shift_y exp %0d got %0d", $signed(e.sy), shift_y); errs++;
        end
        if (shift_z !== e.sz) begin
          $error("shift_z exp %0d got %0d", $signed(e.sz), shift_z); errs++;
        end
        if (found !== e.found) begin
          $error("found exp %0d got %0d", e.found, found); errs++;
        end
        if (last !== e.last) begin
          $error("last exp %0d got %0d", e.last, last); errs++;
        end
      end
    end
  end

  task automatic add_cmd(input logic op, input int idx, input logic [CB-1:0] x,
                         input logic [CB-1:0] y, input logic [CB-1:0] z);
    cmd_t c;
    c.op = op; c.idx = IDX_BITS'(idx); c.x = x; c.y = y; c.z = z;
    if (op == OP_WRITE) staged[idx] = 1'b1;
    cmd_q = {cmd_q, c};
  endtask

  // Write all registers while the block sits idle.
  task automatic set_regs(input int bx, input int by, input int bz,
                          input int cr, input int cn, input int idle);
    int v [5];
    v = '{bx, by, bz, cr, cn};
    for (int i = 0; i < 5; i++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_index <= i[CFG_IDX_BITS-1:0];
      cfg_data <= v[i][CFG_BITS-1:0];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    box_len[0] = CB'(bx); box_len[1] = CB'(by); box_len[2] = CB'(bz);
    cut_r = CB'(cr); scan_cnt = CNT_BITS'(cn);
    sender_idle = idle;
  endtask

  // Mostly inside the box, some near its faces, a few anywhere.
  function automatic logic [CB-1:0] pick_coord(input int len);
    int r;
    r = $urandom_range(99);
    if (r < 10) return CB'($urandom_range(2 ** CB - 1));
    if (r < 30)
      return (r & 1) ? CB'($urandom_range(len < 300 ? len - 1 : 299))
                     : CB'(len - 1 - $urandom_range(len < 300 ? len - 1 : 299));
    return CB'($urandom_range(len - 1));
  endfunction

  // Mixed writes and queries; queries only touch atoms already written.
  task automatic random_cmds(input int n);
    int scan, ci;
    bit ok;
    scan = (scan_cnt > NATOM) ? NATOM : scan_cnt;
    for (int k = 0; k < n; k++) begin
      ci = $urandom_range(NATOM - 1);
      ok = staged[ci];
      for (int j = 0; j < scan; j++) ok &= staged[j];
      if (ok && $urandom_range(99) < 55)
        add_cmd(OP_QUERY, ci, CB'($urandom), CB'($urandom), CB'($urandom));
      else
        add_cmd(OP_WRITE, ci, pick_coord(box_len[0]), pick_coord(box_len[1]),
                pick_coord(box_len[2]));
    end
  endtask

  // Let the stream drain, then cover the tail of a trailing write.
  task automatic drain;
    while (cmd_q.size() > 0 || start || pair_q.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  initial begin
    int bx;
    for (int i = 0; i < NATOM; i++) staged[i] = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: coordinate extremes, wrap at the largest box, off-scan center
    set_regs(1048575, 1048575, 1048575, 1048575, 3, 11);
    add_cmd(OP_WRITE, 0, '0, '0, '0);
    add_cmd(OP_WRITE, 1, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
    add_cmd(OP_WRITE, 2, 20'h80000, 20'h7FFFF, 20'd1);
    add_cmd(OP_QUERY, 0, '0, '0, '0);
    add_cmd(OP_QUERY, 1, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
    add_cmd(OP_QUERY, 2, '0, '0, '0);
    add_cmd(OP_WRITE, 63, 20'h55555, 20'hAAAAA, 20'h12345);
    add_cmd(OP_QUERY, 63, '0, '0, '0);
    drain();

    // Smallest box, positions far outside it; load every atom first
    set_regs(1, 1, 1, 1, 64, 11);
    for (int i = 0; i < NATOM; i++)
      add_cmd(OP_WRITE, i, CB'($urandom_range(3)), CB'($urandom_range(3)),
              CB'($urandom_range(3)));
    random_cmds(40);
    drain();

    // Moderate box with a dense neighborhood
    set_regs(4096, 5000, 3000, 2000, 64, 62);
    for (int i = 0; i < NATOM; i++)
      add_cmd(OP_WRITE, i, pick_coord(4096), pick_coord(5000), pick_coord(3000));
    random_cmds(30);
    drain();

    // Maximum cutoff and oversized count: pair cap reached
    set_regs(1048575, 1, 700000, 1048575, 127, 62);
    random_cmds(40);
    drain();

    // Zero cutoff and zero count: only empty answers
    set_regs(1, 1048575, 1, 0, 0, 0);
    random_cmds(20);
    drain();

    // Random box, partial scan
    bx = $urandom_range(1000, 200000);
    set_regs(bx, bx + $urandom_range(500), bx - $urandom_range(500), bx / 3, 20, 0);
    random_cmds(100);
    drain();

    if (errs == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

  initial begin
    #5ms;
    $display("tb NOT OK");
    $finish;
  end
endmodule
